@@ rtl/ffba_pkg.sv @@
// shared constants, command codes and controller/datapath signal types
`timescale 1ns / 1ps

package ffba_pkg;

   localparam int ARENA_GRANULES_DEFAULT = 1024;
   localparam int GRANULE_BYTES = 32;
   localparam int GRANULE_SHIFT = 5;
   localparam int CMD_W = 2;
   localparam int BYTES_W = 15;
   localparam int ADDR_W = 15;
   localparam int NEED_W = BYTES_W + 1 - GRANULE_SHIFT;
   localparam int REL_W = ADDR_W - GRANULE_SHIFT;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_CAPTURE,
      DP_READ,
      DP_WALK,
      DP_PTR_REL,
      DP_PTR_PREV,
      DP_WRITE_REM,
      DP_WRITE_TAKEN,
      DP_MERGE_NEXT,
      DP_MERGE_PREV,
      DP_WRITE_H_KEEP,
      DP_WRITE_H_DROP,
      DP_RELINK,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      fail;
   } dp_cmd_type;

   typedef struct packed {
      logic             rd_valid;
      logic             rd_free;
      logic             fits;
      logic             exact;
      logic             in_range;
      logic             last;
      logic             hdr_zero;
      logic             rel_bad;
      logic [CMD_W-1:0] cmd;
   } dp_status_type;

endpackage

@@ rtl/ffba_req_if.sv @@
// request channel: command, byte count and block address
`timescale 1ns / 1ps

interface ffba_req_if import ffba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [BYTES_W-1:0] request_bytes;
   logic [ADDR_W-1:0]  block_address;

   modport source (output valid, output cmd, output request_bytes, output block_address,
                   input ready);
   modport sink (input valid, input cmd, input request_bytes, input block_address,
                 output ready);
endinterface

@@ rtl/ffba_rsp_if.sv @@
// response channel: status, payload address and largest free size
`timescale 1ns / 1ps

interface ffba_rsp_if import ffba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [ADDR_W-1:0] payload_address;
   logic [ADDR_W-1:0] largest_free_bytes;

   modport source (output valid, output status, output payload_address,
                   output largest_free_bytes, input ready);
   modport sink (input valid, input status, input payload_address,
                 input largest_free_bytes, output ready);
endinterface

@@ rtl/first_fit_block_allocator_core.sv @@
// First-fit block allocator over an arena of ARENA_GRANULES 32-byte granules, each block
// carrying a one-granule header (valid, free, size, previous-block link) in a header ram
// with one write port and one registered read port. After reset a clearing pass writes
// every header before the first request is taken. Allocate and report walk the block
// chain with one ram read and one evaluate step per header visited, plus dispatch and
// response states; an allocate that splits also writes the remainder header and
// relinks the following block. Release merges the freed block with its free neighbours
// through read-modify-write steps on the header ram. One request is in progress at a
// time; a new request is taken while the previous response still waits in the output
// register.
`timescale 1ns / 1ps

module first_fit_block_allocator_core import ffba_pkg::*; #(
   parameter int ARENA_GRANULES = ARENA_GRANULES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ffba_req_if.sink   req_bus,
   ffba_rsp_if.source rsp_bus
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ffba_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .dp_status(dp_status),
      .dp_cmd   (dp_cmd)
   );

   ffba_datapath #(
      .ARENA_GRANULES(ARENA_GRANULES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .dp_cmd                (dp_cmd),
      .dp_status             (dp_status),
      .req_cmd               (req_bus.cmd),
      .req_request_bytes     (req_bus.request_bytes),
      .req_block_address     (req_bus.block_address),
      .rsp_status            (rsp_bus.status),
      .rsp_payload_address   (rsp_bus.payload_address),
      .rsp_largest_free_bytes(rsp_bus.largest_free_bytes)
   );

endmodule

@@ rtl/ffba_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/ffba_datapath.sv @@
// header store, walk pointer, block registers and response registers
`timescale 1ns / 1ps

module ffba_datapath import ffba_pkg::*; #(
   parameter int ARENA_GRANULES = ARENA_GRANULES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         dp_cmd,
   output dp_status_type      dp_status,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0]  req_block_address,
   output logic               rsp_status,
   output logic [ADDR_W-1:0]  rsp_payload_address,
   output logic [ADDR_W-1:0]  rsp_largest_free_bytes
);

   localparam int AW = $clog2(ARENA_GRANULES);
   localparam int PW = AW + 1;
   localparam int WW = 2 + 2 * AW;
   localparam int CW = (PW > REL_W) ? PW : REL_W;
   localparam int SW = (AW > NEED_W) ? AW : NEED_W;
   localparam logic [PW-1:0] ARENA_END = PW'(ARENA_GRANULES);
   localparam logic [PW-1:0] ARENA_LAST = PW'(ARENA_GRANULES - 1);
   localparam logic [WW-1:0] INIT_WORD = {1'b1, 1'b1, AW'(ARENA_GRANULES - 1), {AW{1'b0}}};

   logic [PW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      hdr_ff, hdr_in;
   logic [AW-1:0]      hsize_ff, hsize_in;
   logic [AW-1:0]      hprev_ff, hprev_in;
   logic [AW-1:0]      lnk_ff, lnk_in;
   logic [AW-1:0]      best_ff, best_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [REL_W-1:0]   relh_ff, relh_in;
   logic               badaddr_ff, badaddr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic               fail_ff, fail_in;
   logic               status_ff, status_in;
   logic [ADDR_W-1:0]  paddr_ff, paddr_in;
   logic [ADDR_W-1:0]  largest_ff, largest_in;

   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr;
   logic [WW-1:0]      mem_wdata, rdata;

   logic               rd_valid, rd_free;
   logic [AW-1:0]      rd_size, rd_prev;
   logic [AW-1:0]      ptr_addr, need_a, merge_sum, rem_idx, rem_size;
   logic [PW-1:0]      next_ptr;
   logic [CW-1:0]      hdr_plus1, best_w;
   logic [BYTES_W:0]   bytes_sum;
   logic [NEED_W-1:0]  need_raw;

   ffba_ram #(
      .WIDTH(WW),
      .DEPTH(ARENA_GRANULES)
   ) u_hdr_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(ptr_addr),
      .rdata(rdata)
   );

   assign rd_valid = rdata[WW-1];
   assign rd_free = rdata[WW-2];
   assign rd_size = rdata[2*AW-1:AW];
   assign rd_prev = rdata[AW-1:0];

   assign ptr_addr = ptr_ff[AW-1:0];
   assign need_a = AW'(need_ff);
   assign next_ptr = ptr_ff + PW'(1) + PW'(rd_size);
   assign merge_sum = hsize_ff + rd_size + AW'(1);
   assign rem_idx = hdr_ff + AW'(1) + need_a;
   assign rem_size = hsize_ff - need_a - AW'(1);
   assign hdr_plus1 = CW'(hdr_ff) + CW'(1);
   assign best_w = CW'(best_ff);
   assign bytes_sum = {1'b0, req_request_bytes} + (BYTES_W + 1)'(GRANULE_BYTES - 1);
   assign need_raw = bytes_sum[BYTES_W:GRANULE_SHIFT];

   always_comb begin
      dp_status.rd_valid = rd_valid;
      dp_status.rd_free = rd_free;
      dp_status.fits = SW'(rd_size) >= SW'(need_ff);
      dp_status.exact = SW'(rd_size) == SW'(need_ff);
      dp_status.in_range = ptr_ff < ARENA_END;
      dp_status.last = ptr_ff == ARENA_LAST;
      dp_status.hdr_zero = hdr_ff == '0;
      dp_status.rel_bad = badaddr_ff || (CW'(relh_ff) >= CW'(ARENA_GRANULES));
      dp_status.cmd = cmd_ff;
   end

   always_comb begin
      ptr_in = ptr_ff;
      hdr_in = hdr_ff;
      hsize_in = hsize_ff;
      hprev_in = hprev_ff;
      lnk_in = lnk_ff;
      best_in = best_ff;
      need_in = need_ff;
      relh_in = relh_ff;
      badaddr_in = badaddr_ff;
      cmd_in = cmd_ff;
      fail_in = fail_ff | dp_cmd.fail;
      status_in = status_ff;
      paddr_in = paddr_ff;
      largest_in = largest_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = ptr_addr;
      mem_wdata = '0;
      case (dp_cmd.op)
         DP_CLEAR: begin
            mem_we = 1'b1;
            mem_wdata = (ptr_ff == '0) ? INIT_WORD : '0;
            ptr_in = ptr_ff + PW'(1);
         end
         DP_CAPTURE: begin
            cmd_in = req_cmd;
            need_in = (need_raw == '0) ? NEED_W'(1) : need_raw;
            relh_in = req_block_address[ADDR_W-1:GRANULE_SHIFT] - REL_W'(1);
            badaddr_in = (req_block_address == '0) ||
                         (req_block_address[GRANULE_SHIFT-1:0] != '0);
            ptr_in = '0;
            best_in = '0;
            fail_in = 1'b0;
         end
         DP_READ: begin
            mem_re = 1'b1;
         end
         DP_WALK: begin
            hdr_in = ptr_addr;
            hsize_in = rd_size;
            hprev_in = rd_prev;
            ptr_in = next_ptr;
            if (rd_valid && rd_free && (rd_size > best_ff)) begin
               best_in = rd_size;
            end
         end
         DP_PTR_REL: begin
            ptr_in = PW'(relh_ff);
         end
         DP_PTR_PREV: begin
            ptr_in = PW'(hprev_ff);
         end
         DP_WRITE_REM: begin
            mem_we = 1'b1;
            mem_waddr = rem_idx;
            mem_wdata = {1'b1, 1'b1, rem_size, hdr_ff};
            lnk_in = rem_idx;
         end
         DP_WRITE_TAKEN: begin
            mem_we = 1'b1;
            mem_waddr = hdr_ff;
            mem_wdata = {1'b1, 1'b0, need_a, hprev_ff};
         end
         DP_MERGE_NEXT: begin
            mem_we = 1'b1;
            mem_wdata = {1'b0, rd_free, rd_size, rd_prev};
            hsize_in = merge_sum;
            ptr_in = PW'(hdr_ff) + PW'(1) + PW'(merge_sum);
            lnk_in = hdr_ff;
         end
         DP_MERGE_PREV: begin
            mem_we = 1'b1;
            mem_wdata = {1'b1, 1'b1, merge_sum, rd_prev};
            ptr_in = ptr_ff + PW'(1) + PW'(merge_sum);
            lnk_in = ptr_addr;
         end
         DP_WRITE_H_KEEP: begin
            mem_we = 1'b1;
            mem_waddr = hdr_ff;
            mem_wdata = {1'b1, 1'b1, hsize_ff, hprev_ff};
         end
         DP_WRITE_H_DROP: begin
            mem_we = 1'b1;
            mem_waddr = hdr_ff;
            mem_wdata = {1'b0, 1'b1, hsize_ff, hprev_ff};
         end
         DP_RELINK: begin
            mem_we = 1'b1;
            mem_wdata = {rd_valid, rd_free, rd_size, lnk_ff};
         end
         DP_PUBLISH: begin
            status_in = fail_ff;
            paddr_in = ((cmd_ff == CMD_ALLOC) && !fail_ff) ?
                       {hdr_plus1[REL_W-1:0], {GRANULE_SHIFT{1'b0}}} : '0;
            largest_in = (cmd_ff == CMD_REPORT) ?
                         {best_w[REL_W-1:0], {GRANULE_SHIFT{1'b0}}} : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         fail_ff <= 1'b0;
         cmd_ff <= CMD_ALLOC;
      end else begin
         ptr_ff <= ptr_in;
         fail_ff <= fail_in;
         cmd_ff <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      hsize_ff <= hsize_in;
      hprev_ff <= hprev_in;
      lnk_ff <= lnk_in;
      best_ff <= best_in;
      need_ff <= need_in;
      relh_ff <= relh_in;
      badaddr_ff <= badaddr_in;
      status_ff <= status_in;
      paddr_ff <= paddr_in;
      largest_ff <= largest_in;
   end

   assign rsp_status = status_ff;
   assign rsp_payload_address = paddr_ff;
   assign rsp_largest_free_bytes = largest_ff;

endmodule

@@ rtl/ffba_controller.sv @@
// sequencer for clearing, allocate walk, release merging and report walk
`timescale 1ns / 1ps

module ffba_controller import ffba_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_A_READ,
      ST_A_EVAL,
      ST_A_SPLIT,
      ST_A_TAKE,
      ST_R_CHECK,
      ST_R_READ_H,
      ST_R_EVAL_H,
      ST_R_READ_N,
      ST_R_EVAL_N,
      ST_R_PREV_SEL,
      ST_R_READ_P,
      ST_R_EVAL_P,
      ST_R_WRITE_HG,
      ST_R_WRITE_HF,
      ST_RL_READ,
      ST_RL_WRITE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ret_prev_ff, ret_prev_in;
   logic      split_ff, split_in;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type relink_ret;

   assign relink_ret = ret_prev_ff ? ST_R_PREV_SEL : ST_DONE;

   always_comb begin
      state_in = state_ff;
      ret_prev_in = ret_prev_ff;
      split_in = split_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd.op = DP_NOP;
      dp_cmd.fail = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.op = DP_CLEAR;
            if (dp_status.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = DP_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            ret_prev_in = 1'b0;
            if ((dp_status.cmd == CMD_ALLOC) || (dp_status.cmd == CMD_REPORT)) begin
               state_in = ST_A_READ;
            end else if (dp_status.cmd == CMD_RELEASE) begin
               state_in = ST_R_CHECK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_A_READ: begin
            if (dp_status.in_range) begin
               dp_cmd.op = DP_READ;
               state_in = ST_A_EVAL;
            end else begin
               dp_cmd.fail = dp_status.cmd == CMD_ALLOC;
               state_in = ST_DONE;
            end
         end
         ST_A_EVAL: begin
            dp_cmd.op = DP_WALK;
            if (!dp_status.rd_valid) begin
               dp_cmd.fail = dp_status.cmd == CMD_ALLOC;
               state_in = ST_DONE;
            end else if ((dp_status.cmd == CMD_ALLOC) && dp_status.rd_free &&
                         dp_status.fits) begin
               split_in = !dp_status.exact;
               state_in = dp_status.exact ? ST_A_TAKE : ST_A_SPLIT;
            end else begin
               state_in = ST_A_READ;
            end
         end
         ST_A_SPLIT: begin
            dp_cmd.op = DP_WRITE_REM;
            state_in = ST_A_TAKE;
         end
         ST_A_TAKE: begin
            dp_cmd.op = DP_WRITE_TAKEN;
            state_in = split_ff ? ST_RL_READ : ST_DONE;
         end
         ST_R_CHECK: begin
            if (dp_status.rel_bad) begin
               dp_cmd.fail = 1'b1;
               state_in = ST_DONE;
            end else begin
               dp_cmd.op = DP_PTR_REL;
               state_in = ST_R_READ_H;
            end
         end
         ST_R_READ_H: begin
            dp_cmd.op = DP_READ;
            state_in = ST_R_EVAL_H;
         end
         ST_R_EVAL_H: begin
            if (!dp_status.rd_valid || dp_status.rd_free) begin
               dp_cmd.fail = 1'b1;
               state_in = ST_DONE;
            end else begin
               dp_cmd.op = DP_WALK;
               state_in = ST_R_READ_N;
            end
         end
         ST_R_READ_N: begin
            if (dp_status.in_range) begin
               dp_cmd.op = DP_READ;
               state_in = ST_R_EVAL_N;
            end else begin
               state_in = ST_R_PREV_SEL;
            end
         end
         ST_R_EVAL_N: begin
            if (dp_status.rd_valid && dp_status.rd_free) begin
               dp_cmd.op = DP_MERGE_NEXT;
               ret_prev_in = 1'b1;
               state_in = ST_RL_READ;
            end else begin
               state_in = ST_R_PREV_SEL;
            end
         end
         ST_R_PREV_SEL: begin
            ret_prev_in = 1'b0;
            if (dp_status.hdr_zero) begin
               state_in = ST_R_WRITE_HF;
            end else begin
               dp_cmd.op = DP_PTR_PREV;
               state_in = ST_R_READ_P;
            end
         end
         ST_R_READ_P: begin
            if (dp_status.in_range) begin
               dp_cmd.op = DP_READ;
               state_in = ST_R_EVAL_P;
            end else begin
               state_in = ST_R_WRITE_HF;
            end
         end
         ST_R_EVAL_P: begin
            if (dp_status.rd_valid && dp_status.rd_free) begin
               dp_cmd.op = DP_MERGE_PREV;
               state_in = ST_R_WRITE_HG;
            end else begin
               state_in = ST_R_WRITE_HF;
            end
         end
         ST_R_WRITE_HG: begin
            dp_cmd.op = DP_WRITE_H_DROP;
            ret_prev_in = 1'b0;
            state_in = ST_RL_READ;
         end
         ST_R_WRITE_HF: begin
            dp_cmd.op = DP_WRITE_H_KEEP;
            state_in = ST_DONE;
         end
         ST_RL_READ: begin
            if (dp_status.in_range) begin
               dp_cmd.op = DP_READ;
               state_in = ST_RL_WRITE;
            end else begin
               state_in = relink_ret;
            end
         end
         ST_RL_WRITE: begin
            if (dp_status.rd_valid) begin
               dp_cmd.op = DP_RELINK;
            end
            state_in = relink_ret;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.op = DP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ret_prev_ff <= 1'b0;
         split_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_prev_ff <= ret_prev_in;
         split_ff <= split_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ bench/first_fit_block_allocator_core_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for the first-fit allocator: corner cases, random traffic and back-pressure

module first_fit_block_allocator_core_test;
   import ffba_pkg::*;

   localparam int GRANULES = ARENA_GRANULES_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * GRANULES + 64;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] payload_address;
      logic [ADDR_W-1:0] largest_free_bytes;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ffba_req_if req_bus ();
   ffba_rsp_if rsp_bus ();

   first_fit_block_allocator_core #(.ARENA_GRANULES(GRANULES)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bit          blk_valid [GRANULES];
   bit          blk_free  [GRANULES];
   int unsigned blk_size  [GRANULES];
   int unsigned blk_prev  [GRANULES];

   alloc_rsp_type     awaited_rsp [$];
   logic [ADDR_W-1:0] live_blocks [$];
   logic [ADDR_W-1:0] retired_blocks [$];

   int error_count = 0;
   int hold_rsp_cycles = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   always #2 clock = ~clock;

   function automatic int unsigned next_hdr(int unsigned h);
      return h + 1 + blk_size[h];
   endfunction

   function automatic void relink_after(int unsigned h);
      int unsigned n;
      n = next_hdr(h);
      if (n < GRANULES && blk_valid[n]) begin
         blk_prev[n] = h;
      end
   endfunction

   function automatic void arena_clear();
      for (int g = 0; g < GRANULES; g++) begin
         blk_valid[g] = 1'b0;
         blk_free[g] = 1'b0;
         blk_size[g] = 0;
         blk_prev[g] = 0;
      end
      blk_valid[0] = 1'b1;
      blk_free[0] = 1'b1;
      blk_size[0] = GRANULES - 1;
   endfunction

   function automatic alloc_rsp_type arena_step(input logic [CMD_W-1:0] cmd,
                                                input logic [BYTES_W-1:0] bytes,
                                                input logic [ADDR_W-1:0] addr);
      alloc_rsp_type r;
      int unsigned   need, h, n, p, best;
      bit            placed;
      r = '0;
      h = 0;
      case (cmd)
         CMD_ALLOC: begin
            need = (int'(bytes) + GRANULE_BYTES - 1) / GRANULE_BYTES;
            if (need == 0) begin
               need = 1;
            end
            placed = 1'b0;
            while (!placed && h < GRANULES && blk_valid[h]) begin
               if (blk_free[h] && blk_size[h] >= need) begin
                  if (blk_size[h] > need) begin
                     n = h + 1 + need;
                     blk_valid[n] = 1'b1;
                     blk_free[n] = 1'b1;
                     blk_size[n] = blk_size[h] - need - 1;
                     blk_prev[n] = h;
                     blk_size[h] = need;
                     relink_after(n);
                  end
                  blk_free[h] = 1'b0;
                  r.payload_address = ADDR_W'((h + 1) * GRANULE_BYTES);
                  placed = 1'b1;
               end else begin
                  h = next_hdr(h);
               end
            end
            r.status = !placed;
         end
         CMD_RELEASE: begin
            h = int'(addr) / GRANULE_BYTES - 1;
            if (addr == '0 || int'(addr) % GRANULE_BYTES != 0 || h >= GRANULES
                || !blk_valid[h] || blk_free[h]) begin
               r.status = 1'b1;
            end else begin
               blk_free[h] = 1'b1;
               n = next_hdr(h);
               if (n < GRANULES && blk_valid[n] && blk_free[n]) begin
                  blk_size[h] += 1 + blk_size[n];
                  blk_valid[n] = 1'b0;
                  relink_after(h);
               end
               if (h > 0) begin
                  p = blk_prev[h];
                  if (p < GRANULES && blk_valid[p] && blk_free[p]) begin
                     blk_size[p] += 1 + blk_size[h];
                     blk_valid[h] = 1'b0;
                     relink_after(p);
                  end
               end
            end
         end
         CMD_REPORT: begin
            best = 0;
            while (h < GRANULES && blk_valid[h]) begin
               if (blk_free[h] && blk_size[h] > best) begin
                  best = blk_size[h];
               end
               h = next_hdr(h);
            end
            r.largest_free_bytes = ADDR_W'(best * GRANULE_BYTES);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            flag_mismatch("response with nothing outstanding, status", rsp_bus.status, 0);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_bus.status !== want.status) begin
               flag_mismatch("status", rsp_bus.status, want.status);
            end
            if (rsp_bus.payload_address !== want.payload_address) begin
               flag_mismatch("payload_address", rsp_bus.payload_address,
                             want.payload_address);
            end
            if (rsp_bus.largest_free_bytes !== want.largest_free_bytes) begin
               flag_mismatch("largest_free_bytes", rsp_bus.largest_free_bytes,
                             want.largest_free_bytes);
            end
         end
      end
   end

   // receiver: long hold-off, random stall bursts, or ready
   initial begin
      int burst;
      burst = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_cycles > 0) begin
            hold_rsp_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 15) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTES_W-1:0] bytes,
                            input logic [ADDR_W-1:0] addr);
      alloc_rsp_type r;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.request_bytes <= bytes;
      req_bus.block_address <= addr;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      r = arena_step(cmd, bytes, addr);
      awaited_rsp.push_back(r);
      if (cmd == CMD_ALLOC && !r.status) begin
         live_blocks.push_back(r.payload_address);
      end
      if (cmd == CMD_RELEASE && !r.status) begin
         for (int i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == addr) begin
               live_blocks.delete(i);
               break;
            end
         end
         retired_blocks.push_back(addr);
         if (retired_blocks.size() > 16) begin
            void'(retired_blocks.pop_front());
         end
      end
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   task automatic send_random_item();
      logic [CMD_W-1:0]   cmd;
      logic [BYTES_W-1:0] bytes;
      logic [ADDR_W-1:0]  addr;
      int unsigned        pick, sel;
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      bytes = BYTES_W'($urandom);
      addr = ADDR_W'($urandom);
      if (pick < (live_blocks.size() > 40 ? 25 : 50)) begin
         cmd = CMD_ALLOC;
         if (sel == 0) begin
            bytes = '0;
         end else if (sel < 4) begin
            bytes = BYTES_W'($urandom_range(1, 4096));
         end else if (sel > 4) begin
            bytes = BYTES_W'($urandom_range(1, 320));
         end
      end else if (pick < 88) begin
         cmd = CMD_RELEASE;
         if (sel < 16 && live_blocks.size() != 0) begin
            addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         end else if (sel < 18 && retired_blocks.size() != 0) begin
            addr = retired_blocks[$urandom_range(0, retired_blocks.size() - 1)];
         end else if (sel < 19) begin
            addr = ADDR_W'($urandom_range(1, GRANULES - 1) * GRANULE_BYTES);
         end
      end else if (pick < 97) begin
         cmd = CMD_REPORT;
      end else begin
         cmd = CMD_UNUSED;
      end
      send_item(cmd, bytes, addr);
   endtask

   task automatic test_directed_corners();
      send_item(CMD_REPORT, '0, '0);
      send_item(CMD_ALLOC, 15'h7FFF, '0);
      // whole arena in one block, then nothing left
      send_item(CMD_ALLOC, 15'd32736, '0);
      send_item(CMD_REPORT, '0, '0);
      send_item(CMD_ALLOC, '0, '0);
      send_item(CMD_RELEASE, '0, 15'd32);
      send_item(CMD_RELEASE, '0, 15'd32);
      // g0 size 1, g2 size 1, g4 size 2, g7 size 2
      send_item(CMD_ALLOC, '0, '0);
      send_item(CMD_ALLOC, 15'd1, '0);
      send_item(CMD_ALLOC, 15'd33, '0);
      send_item(CMD_ALLOC, 15'd64, 15'h7FFF);
      send_item(CMD_RELEASE, '0, '0);
      send_item(CMD_RELEASE, '0, 15'h7FFF);
      send_item(CMD_RELEASE, '0, 15'd64);
      send_item(CMD_UNUSED, 15'h7FFF, 15'h7FFF);
      // free with no merge, then merge with previous, then next, then both
      send_item(CMD_RELEASE, '0, 15'd96);
      send_item(CMD_RELEASE, '0, 15'd160);
      send_item(CMD_RELEASE, '0, 15'd32);
      send_item(CMD_RELEASE, '0, 15'd256);
      send_item(CMD_REPORT, '0, '0);
      // split leaving an empty remainder block
      send_item(CMD_ALLOC, 15'd32704, '0);
      send_item(CMD_REPORT, '0, '0);
      send_item(CMD_ALLOC, '0, '0);
      send_item(CMD_RELEASE, '0, 15'd32);
      send_item(CMD_REPORT, '0, '0);
   endtask

   task automatic test_random_traffic();
      repeat (1600) send_random_item();
   endtask

   task automatic test_rsp_backpressure();
      hold_rsp_cycles = 300;
      repeat (40) send_random_item();
      wait_for_results();
   endtask

   task automatic test_drain_pause();
      repeat (20) send_random_item();
      wait_for_results();
      repeat (20) send_random_item();
   endtask

   task automatic test_streaming();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (300) send_random_item();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_ALLOC;
      req_bus.request_bytes = '0;
      req_bus.block_address = '0;
      arena_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_traffic();
      test_rsp_backpressure();
      test_drain_pause();
      test_streaming();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
